// ===== hw/rtl/tssd_pkg.sv =====
// tssd_pkg: shared types and constants for the tile ssd best-match block
// holds the pixel pair and match item structs, field widths and saturation bound
// no dependencies
`timescale 1ns / 1ps

package tssd_pkg;

    // field widths
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned SQ_W     = 2 * CHAN_W;
    localparam int unsigned SQSUM_W  = SQ_W + 2;
    localparam int unsigned SUM_W    = 34;
    localparam int unsigned IDX_W    = 10;

    // running sum saturates at all ones
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // one pixel pair item
    typedef struct packed {
        logic [CHAN_W-1:0] tile_blue;
        logic [CHAN_W-1:0] tile_green;
        logic [CHAN_W-1:0] tile_red;
        logic [CHAN_W-1:0] cand_blue;
        logic [CHAN_W-1:0] cand_green;
        logic [CHAN_W-1:0] cand_red;
        logic              last_pixel;
        logic              last_candidate;
    } pair_t;

    // one match result item
    typedef struct packed {
        logic [IDX_W-1:0] best_index;
        logic [SUM_W-1:0] best_distance;
    } match_t;

endpackage

// ===== hw/rtl/tssd_sq_sum.sv =====
// tssd_sq_sum: sum of squared differences over the three bgr channels of a pair
// combinational; uses tssd_pkg for the pair item type and widths
`timescale 1ns / 1ps

module tssd_sq_sum
(
    input  tssd_pkg::pair_t                   pair,
    output logic [tssd_pkg::SQSUM_W-1:0]      sq_sum
);

    logic [tssd_pkg::CHAN_W-1:0] diff_b;
    logic [tssd_pkg::CHAN_W-1:0] diff_g;
    logic [tssd_pkg::CHAN_W-1:0] diff_r;
    logic [tssd_pkg::SQ_W-1:0]   sq_b;
    logic [tssd_pkg::SQ_W-1:0]   sq_g;
    logic [tssd_pkg::SQ_W-1:0]   sq_r;

    // absolute channel differences
    always_comb
    begin
        diff_b = (pair.tile_blue >= pair.cand_blue) ? (pair.tile_blue - pair.cand_blue)
                                                    : (pair.cand_blue - pair.tile_blue);
        diff_g = (pair.tile_green >= pair.cand_green) ? (pair.tile_green - pair.cand_green)
                                                      : (pair.cand_green - pair.tile_green);
        diff_r = (pair.tile_red >= pair.cand_red) ? (pair.tile_red - pair.cand_red)
                                                  : (pair.cand_red - pair.tile_red);
    end

    // 8x8 squares and their sum
    always_comb
    begin
        sq_b   = tssd_pkg::SQ_W'(diff_b) * tssd_pkg::SQ_W'(diff_b);
        sq_g   = tssd_pkg::SQ_W'(diff_g) * tssd_pkg::SQ_W'(diff_g);
        sq_r   = tssd_pkg::SQ_W'(diff_r) * tssd_pkg::SQ_W'(diff_r);
        sq_sum = tssd_pkg::SQSUM_W'(sq_b) + tssd_pkg::SQSUM_W'(sq_g)
               + tssd_pkg::SQSUM_W'(sq_r);
    end

endmodule

// ===== hw/rtl/tile_ssd_best_match.sv =====
// tile_ssd_best_match: streams pixel pairs, returns the best candidate per tile
// the last pair of the last candidate passes the squares register, then the output register
// throughput: one pair item per cycle; the squares are registered, then one
// 34-bit accumulate-and-compare per cycle updates the running state
// input only stalls when a finished match is still waiting and another is due
// reset (rst_n, async low) clears pipeline valids and the search state
`timescale 1ns / 1ps

module tile_ssd_best_match
#(
    parameter int unsigned MAX_CANDIDATES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pair_valid,
    output logic              pair_ready,
    input  tssd_pkg::pair_t   pair,
    output logic              match_valid,
    input  logic              match_ready,
    output tssd_pkg::match_t  match
);

    localparam int unsigned CAND_W = (MAX_CANDIDATES > 2) ? $clog2(MAX_CANDIDATES) : 1;
    localparam logic [CAND_W-1:0] CAND_LAST = CAND_W'(MAX_CANDIDATES - 1);

    // squares stage registers
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic [tssd_pkg::SQSUM_W-1:0]    s1_sq_reg;
    logic                            s1_last_px_reg;
    logic                            s1_last_cand_reg;
    logic [tssd_pkg::SQSUM_W-1:0]    sq_sum;

    // search state
    logic [tssd_pkg::SUM_W-1:0]      run_sum_reg;
    logic [tssd_pkg::SUM_W-1:0]      run_sum_next;
    logic [tssd_pkg::SUM_W-1:0]      low_sum_reg;
    logic [tssd_pkg::SUM_W-1:0]      low_sum_next;
    logic [tssd_pkg::IDX_W-1:0]      low_idx_reg;
    logic [tssd_pkg::IDX_W-1:0]      low_idx_next;
    logic [CAND_W-1:0]               cand_reg;
    logic [CAND_W-1:0]               cand_next;

    // output register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    tssd_pkg::match_t                out_reg;
    tssd_pkg::match_t                out_next;

    logic                            is_result;
    logic                            s1_fire;
    logic [tssd_pkg::SUM_W:0]        sum_wide;
    logic [tssd_pkg::SUM_W-1:0]      sum_sat;
    logic                            take;
    logic [tssd_pkg::SUM_W-1:0]      best_sum;
    logic [tssd_pkg::IDX_W-1:0]      best_idx;

    // squared differences of the incoming pair
    tssd_sq_sum u_sq_sum
    (
        .pair   (pair),
        .sq_sum (sq_sum)
    );

    // handshake: squares stage drains unless a second match would overwrite one
    assign is_result  = s1_last_px_reg && s1_last_cand_reg;
    assign s1_fire    = s1_valid_reg && (!is_result || !out_valid_reg || match_ready);
    assign pair_ready = !s1_valid_reg || s1_fire;
    assign s1_valid_next = pair_ready ? pair_valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pair_valid && pair_ready)
        begin
            s1_sq_reg        <= sq_sum;
            s1_last_px_reg   <= pair.last_pixel;
            s1_last_cand_reg <= pair.last_candidate;
        end
    end

    // accumulate with saturation, then strict-less compare at candidate end
    always_comb
    begin
        sum_wide = {1'b0, run_sum_reg} + (tssd_pkg::SUM_W + 1)'(s1_sq_reg);
        sum_sat  = sum_wide[tssd_pkg::SUM_W] ? tssd_pkg::SUM_MAX
                                             : sum_wide[tssd_pkg::SUM_W-1:0];
        take     = (cand_reg == '0) || (sum_sat < low_sum_reg);
        best_sum = take ? sum_sat : low_sum_reg;
        best_idx = take ? tssd_pkg::IDX_W'(cand_reg) : low_idx_reg;
    end

    // next search state and output
    always_comb
    begin
        run_sum_next   = run_sum_reg;
        low_sum_next   = low_sum_reg;
        low_idx_next   = low_idx_reg;
        cand_next      = cand_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !match_ready;
        if (s1_fire)
        begin
            if (!s1_last_px_reg)
            begin
                run_sum_next = sum_sat;
            end
            else if (s1_last_cand_reg)
            begin
                out_next.best_index    = best_idx;
                out_next.best_distance = best_sum;
                out_valid_next         = 1'b1;
                run_sum_next           = '0;
                low_sum_next           = tssd_pkg::SUM_MAX;
                low_idx_next           = '0;
                cand_next              = '0;
            end
            else
            begin
                run_sum_next = '0;
                low_sum_next = best_sum;
                low_idx_next = best_idx;
                if (cand_reg < CAND_LAST)
                begin
                    cand_next = cand_reg + CAND_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_sum_reg   <= '0;
            low_sum_reg   <= tssd_pkg::SUM_MAX;
            low_idx_reg   <= '0;
            cand_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_sum_reg   <= run_sum_next;
            low_sum_reg   <= low_sum_next;
            low_idx_reg   <= low_idx_next;
            cand_reg      <= cand_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign match_valid = out_valid_reg;
    assign match       = out_reg;

    // candidate counter never passes its saturation bound
    a_cand_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cand_reg <= CAND_LAST)
        else $error("candidate counter beyond bound");

    // a pending match is never overwritten by the next one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !match_ready) |-> !(s1_fire && is_result))
        else $error("match overwritten while pending");

    // state is clear after a tile ends
    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && is_result) |=> (cand_reg == '0 && run_sum_reg == '0
                                    && low_sum_reg == tssd_pkg::SUM_MAX))
        else $error("search state not cleared after tile");

    // an empty squares stage always takes an item
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> pair_ready)
        else $error("stalled with empty squares stage");

endmodule
